// File: rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants for the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

	localparam int MaxSegments     = 32;
	localparam int SlotBits        = 16;
	localparam int HeapSlotsReset  = 1024;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_SPACE   = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_BAD_FREE   = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef struct packed {
		logic                mode;
		logic [SlotBits-1:0] range_length;
		logic [SlotBits-1:0] range_start;
	} req_t;

	typedef struct packed {
		logic [SlotBits-1:0] granted_start;
		logic [1:0]          status;
	} rsp_t;

	typedef enum logic [3:0] {
		FS_IDLE,
		FS_SCAN_RD,
		FS_SCAN_CHK,
		FS_DECIDE,
		FS_SHIFT_RD,
		FS_SHIFT_WR,
		FS_WRITE,
		FS_RESP
	} fsm_t;

endpackage

// File: rtl/first_fit_range_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// First-fit allocator of slot ranges over a sorted, coalescing free table.
// ----------------------------------------------------------------------------
// Requests are handled in steps: a scan reads the segment table one entry at
// a time (a read state, then a check state on the registered RAM data) until
// the first fit or the insertion point is found, then a removal or insertion
// moves the tail of the table one entry at a time (a read state, then a write
// state), then the entry is written and the response is raised. Writing
// heap_slots resets the table (count in a register, entry 0 through the RAM
// write port). After reset the block loads entry 0 before it takes requests.
module first_fit_range_allocator #(
	parameter int MAX_SEGMENTS = ffra_pkg::MaxSegments
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  ffra_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output ffra_pkg::rsp_t               rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ffra_pkg::SlotBits-1:0] cfg_data
);

	localparam int SLOT_BITS = ffra_pkg::SlotBits;
	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int EW = 2 * SLOT_BITS;
	localparam int SW = SLOT_BITS + 1;

	ffra_pkg::fsm_t state_q, state_d;

	logic [SLOT_BITS-1:0] heap_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  pos_q;
	logic [CW-1:0]  k_q;
	logic           mode_q;
	logic [SW-1:0]  len_q, start_q;
	logic [SW-1:0]  below_s_q, below_l_q, above_s_q, above_l_q;
	logic           has_below_q, has_above_q, fit_q;
	logic [SLOT_BITS-1:0] grant_q;
	logic [1:0]     status_q;
	logic           rsp_valid_q;
	logic           shift_dir_q;
	logic           init_q;
	logic           idle;

	logic           we;
	logic [IW-1:0]  waddr, raddr;
	logic [EW-1:0]  wdata, rdata;

	ffra_ram #(.Width(EW), .Depth(MAX_SEGMENTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	logic [SW-1:0] rd_s, rd_l;
	assign rd_s = {1'b0, rdata[EW-1:SLOT_BITS]};
	assign rd_l = {1'b0, rdata[SLOT_BITS-1:0]};

	logic [SW-1:0] stop, below_end, sum3;
	assign stop      = start_q + len_q;
	assign below_end = below_s_q + below_l_q;
	assign sum3      = below_l_q + len_q;

	logic join_b, join_a, bad;
	assign join_b = has_below_q && (below_end == start_q);
	assign join_a = has_above_q && (above_s_q == stop);
	assign bad    = (has_below_q && below_end > start_q) || (has_above_q && above_s_q < stop);

	// a pending heap write takes priority over a request
	assign idle      = (state_q == ffra_pkg::FS_IDLE) && !rsp_valid_q && !init_q;
	assign cfg_ready = idle;
	assign req_ready = idle && !cfg_valid;
	assign rsp_valid = rsp_valid_q;
	assign rsp.granted_start = grant_q;
	assign rsp.status        = status_q;

	// entry 0 write on reinit shares the RAM write port with the sequencer
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = pos_q[IW-1:0];
		wdata   = '0;
		raddr   = k_q[IW-1:0];
		if (init_q) begin
			we    = 1'b1;
			waddr = '0;
			wdata = {SLOT_BITS'(1), SLOT_BITS'(heap_q - SLOT_BITS'(1))};
		end
		if (cfg_valid && cfg_ready) begin
			we    = 1'b1;
			waddr = '0;
			wdata = {SLOT_BITS'(1), SLOT_BITS'(cfg_data - SLOT_BITS'(1))};
		end
		case (state_q)
			ffra_pkg::FS_IDLE: begin
				raddr = '0;
				if (req_valid && req_ready) state_d = ffra_pkg::FS_SCAN_RD;
			end
			ffra_pkg::FS_SCAN_RD: begin
				if (k_q >= count_q) state_d = ffra_pkg::FS_DECIDE;
				else                state_d = ffra_pkg::FS_SCAN_CHK;
			end
			ffra_pkg::FS_SCAN_CHK: begin
				if (mode_q == ffra_pkg::MODE_ALLOC) begin
					if (rd_l >= len_q) state_d = ffra_pkg::FS_DECIDE;
					else               state_d = ffra_pkg::FS_SCAN_RD;
				end else begin
					if (rd_s >= start_q) state_d = ffra_pkg::FS_DECIDE;
					else                 state_d = ffra_pkg::FS_SCAN_RD;
				end
			end
			ffra_pkg::FS_DECIDE: state_d = ffra_pkg::FS_WRITE;
			ffra_pkg::FS_SHIFT_RD: state_d = ffra_pkg::FS_SHIFT_WR;
			ffra_pkg::FS_SHIFT_WR: begin
				we    = 1'b1;
				waddr = shift_dir_q ? IW'(k_q + 1'b1) : IW'(k_q - 1'b1);
				wdata = rdata;
				state_d = ffra_pkg::FS_SHIFT_RD;
			end
			ffra_pkg::FS_WRITE: state_d = ffra_pkg::FS_RESP;
			ffra_pkg::FS_RESP: state_d = ffra_pkg::FS_IDLE;
			default: state_d = ffra_pkg::FS_IDLE;
		endcase
		// sequencer-driven entry write
		if (state_q == ffra_pkg::FS_WRITE && fit_q) begin
			we = 1'b1;
			waddr = pos_q[IW-1:0];
			wdata = {below_s_q[SLOT_BITS-1:0], below_l_q[SLOT_BITS-1:0]};
		end
		if (state_q == ffra_pkg::FS_SHIFT_RD) raddr = k_q[IW-1:0];
	end

	// Sequencing: fit_q marks a pending entry write (pos_q, below_*).
	// The shift loop moves entries up (insert, dir 1) or down (remove, dir 0).
	logic [CW-1:0] rm_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffra_pkg::FS_IDLE;
			heap_q      <= SLOT_BITS'(ffra_pkg::HeapSlotsReset);
			count_q     <= CW'(1);
			rsp_valid_q <= 1'b0;
			k_q         <= '0;
			pos_q       <= '0;
			fit_q       <= 1'b0;
			init_q      <= 1'b1;
		end else begin
			init_q <= 1'b0;
			if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				heap_q  <= cfg_data;
				count_q <= (cfg_data >= SLOT_BITS'(2)) ? CW'(1) : CW'(0);
			end
			case (state_q)
				ffra_pkg::FS_IDLE: begin
					if (req_valid && req_ready) begin
						mode_q      <= req.mode;
						len_q       <= {1'b0, req.range_length};
						start_q     <= {1'b0, req.range_start};
						k_q         <= '0;
						has_below_q <= 1'b0;
						has_above_q <= 1'b0;
						fit_q       <= 1'b0;
						grant_q     <= '0;
						state_q     <= ffra_pkg::FS_SCAN_RD;
					end
				end
				ffra_pkg::FS_SCAN_RD: state_q <= state_d;
				ffra_pkg::FS_SCAN_CHK: begin
					if (state_d == ffra_pkg::FS_DECIDE) begin
						has_above_q <= 1'b1;
						above_s_q   <= rd_s;
						above_l_q   <= rd_l;
					end else begin
						has_below_q <= 1'b1;
						below_s_q   <= rd_s;
						below_l_q   <= rd_l;
						k_q         <= k_q + 1'b1;
					end
					state_q <= state_d;
				end
				ffra_pkg::FS_DECIDE: begin
					if (mode_q == ffra_pkg::MODE_ALLOC) begin
						if (len_q == '0 || !has_above_q) begin
							status_q <= ffra_pkg::ST_NO_SPACE;
							state_q  <= ffra_pkg::FS_RESP;
						end else begin
							status_q <= ffra_pkg::ST_OK;
							grant_q  <= above_s_q[SLOT_BITS-1:0];
							if (above_l_q == len_q) begin
								rm_end_q <= count_q;
								count_q  <= count_q - 1'b1;
								k_q      <= k_q + 1'b1;
								shift_dir_q <= 1'b0;
								state_q  <= ffra_pkg::FS_SHIFT_RD;
							end else begin
								fit_q     <= 1'b1;
								pos_q     <= k_q;
								below_s_q <= above_s_q + len_q;
								below_l_q <= above_l_q - len_q;
								state_q   <= ffra_pkg::FS_WRITE;
							end
						end
					end else if (len_q == '0 || start_q == '0 || stop > {1'b0, heap_q} || bad) begin
						status_q <= ffra_pkg::ST_BAD_FREE;
						state_q  <= ffra_pkg::FS_RESP;
					end else if (join_b && join_a) begin
						status_q  <= ffra_pkg::ST_OK;
						fit_q     <= 1'b1;
						pos_q     <= k_q - 1'b1;
						below_l_q <= sum3 + above_l_q;
						rm_end_q  <= count_q;
						count_q   <= count_q - 1'b1;
						k_q       <= k_q + 1'b1;
						shift_dir_q <= 1'b0;
						state_q   <= ffra_pkg::FS_SHIFT_RD;
					end else if (join_b) begin
						status_q  <= ffra_pkg::ST_OK;
						fit_q     <= 1'b1;
						pos_q     <= k_q - 1'b1;
						below_l_q <= sum3;
						state_q   <= ffra_pkg::FS_WRITE;
					end else if (join_a) begin
						status_q  <= ffra_pkg::ST_OK;
						fit_q     <= 1'b1;
						pos_q     <= k_q;
						below_s_q <= start_q;
						below_l_q <= above_l_q + len_q;
						state_q   <= ffra_pkg::FS_WRITE;
					end else if (count_q >= CW'(MAX_SEGMENTS)) begin
						status_q <= ffra_pkg::ST_TABLE_FULL;
						state_q  <= ffra_pkg::FS_RESP;
					end else begin
						status_q  <= ffra_pkg::ST_OK;
						fit_q     <= 1'b1;
						pos_q     <= k_q;
						below_s_q <= start_q;
						below_l_q <= len_q;
						rm_end_q  <= k_q;
						k_q       <= count_q - 1'b1;
						count_q   <= count_q + 1'b1;
						shift_dir_q <= 1'b1;
						state_q   <= (count_q != k_q) ? ffra_pkg::FS_SHIFT_RD
							: ffra_pkg::FS_WRITE;
					end
				end
				ffra_pkg::FS_SHIFT_RD: begin
					// removal runs to the old end; insertion runs down to pos
					if (!shift_dir_q && k_q >= rm_end_q) state_q <= ffra_pkg::FS_WRITE;
					else state_q <= ffra_pkg::FS_SHIFT_WR;
				end
				ffra_pkg::FS_SHIFT_WR: begin
					if (shift_dir_q) begin
						if (k_q == rm_end_q) state_q <= ffra_pkg::FS_WRITE;
						else begin
							k_q     <= k_q - 1'b1;
							state_q <= ffra_pkg::FS_SHIFT_RD;
						end
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ffra_pkg::FS_SHIFT_RD;
					end
				end
				ffra_pkg::FS_WRITE: begin
					state_q <= ffra_pkg::FS_RESP;
				end
				ffra_pkg::FS_RESP: begin
					rsp_valid_q <= 1'b1;
					state_q     <= ffra_pkg::FS_IDLE;
				end
				default: state_q <= ffra_pkg::FS_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SEGMENTS)) else $error("segment count overflow");
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ffra_pkg::FS_IDLE) |-> !req_ready) else $error("ready while busy");
	a_rsp_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffra_pkg::FS_RESP) |=> rsp_valid) else $error("response lost");
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ffra_pkg::ST_OK) |-> rsp.granted_start == '0)
		else $error("grant on failure");
`endif

endmodule

// File: rtl/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram
// Generic single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffra_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit range allocator.
// ----------------------------------------------------------------------------
// Phases of random allocate/free traffic over several heap sizes. The heap
// size is rewritten between phases while the block is idle. Each accepted
// request is run through a local free-table model. Each response is checked
// against the oldest predicted one. The stimulus generator keeps its own copy
// of the table and a list of held ranges, so most frees return real
// allocations (whole or split). The rest is noise.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		int start[ffra_pkg::MaxSegments];
		int len[ffra_pkg::MaxSegments];
		int count;
		int heap;
	} free_table_t;

	typedef struct {
		int s;
		int l;
	} span_t;

	logic clk, arst_n;
	logic req_valid, req_ready, rsp_valid, rsp_ready, cfg_valid, cfg_ready;
	ffra_pkg::req_t req;
	ffra_pkg::rsp_t rsp;
	logic [15:0] cfg_data;

	first_fit_range_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	free_table_t chk_tab, gen_tab;
	span_t held[$];
	ffra_pkg::req_t pending_reqs[$];
	ffra_pkg::rsp_t expected_rsps[$];
	int errors = 0, stall_cycles = 0, idle_mode = 0;
	int tx_idle_pct, rx_idle_pct;
	int n_status[4] = '{0, 0, 0, 0};
	int n_cfg = 0;
	int n_req_acc = 0, n_req_seen = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic void init_table(inout free_table_t t, input int h);
		t.heap = h;
		for (int k = 0; k < ffra_pkg::MaxSegments; k++) begin
			t.start[k] = 0;
			t.len[k] = 0;
		end
		if (h >= 2) begin
			t.start[0] = 1;
			t.len[0] = h - 1;
			t.count = 1;
		end else begin
			t.count = 0;
		end
	endfunction

	// first fit on allocate; coalescing insert on free
	function automatic ffra_pkg::rsp_t ffra_apply(inout free_table_t t,
			input ffra_pkg::req_t r);
		ffra_pkg::rsp_t o;
		int len, st, stop, pos, k;
		bit below, above, jb, ja;
		o = '0;
		len = r.range_length;
		st = r.range_start;
		if (r.mode == ffra_pkg::MODE_ALLOC) begin
			o.status = ffra_pkg::ST_NO_SPACE;
			if (len != 0) begin
				for (k = 0; k < t.count; k++) begin
					if (t.len[k] >= len) begin
						o.granted_start = 16'(t.start[k]);
						o.status = ffra_pkg::ST_OK;
						if (t.len[k] == len) begin
							for (int j = k; j + 1 < t.count; j++) begin
								t.start[j] = t.start[j+1];
								t.len[j] = t.len[j+1];
							end
							t.count--;
						end else begin
							t.start[k] += len;
							t.len[k] -= len;
						end
						break;
					end
				end
			end
			return o;
		end
		stop = st + len;
		o.status = ffra_pkg::ST_BAD_FREE;
		if (len == 0 || st == 0 || stop > t.heap)
			return o;
		pos = 0;
		while (pos < t.count && t.start[pos] < st)
			pos++;
		below = pos > 0;
		above = pos < t.count;
		if (below && t.start[pos-1] + t.len[pos-1] > st)
			return o;
		if (above && t.start[pos] < stop)
			return o;
		jb = below && t.start[pos-1] + t.len[pos-1] == st;
		ja = above && t.start[pos] == stop;
		o.status = ffra_pkg::ST_OK;
		if (jb && ja) begin
			t.len[pos-1] += len + t.len[pos];
			for (int j = pos; j + 1 < t.count; j++) begin
				t.start[j] = t.start[j+1];
				t.len[j] = t.len[j+1];
			end
			t.count--;
		end else if (jb) begin
			t.len[pos-1] += len;
		end else if (ja) begin
			t.start[pos] = st;
			t.len[pos] += len;
		end else begin
			if (t.count >= ffra_pkg::MaxSegments) begin
				o.status = ffra_pkg::ST_TABLE_FULL;
				return o;
			end
			for (k = t.count; k > pos; k--) begin
				t.start[k] = t.start[k-1];
				t.len[k] = t.len[k-1];
			end
			t.start[pos] = st;
			t.len[pos] = len;
			t.count++;
		end
		return o;
	endfunction

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
	endtask

	// queues a request; tracks held ranges against the generator's table
	task automatic push_req(input logic m, input int len, input int st, input int held_idx,
			input int off);
		ffra_pkg::req_t r;
		ffra_pkg::rsp_t o;
		span_t h;
		r.mode = m;
		r.range_length = len[15:0];
		r.range_start = st[15:0];
		o = ffra_apply(gen_tab, r);
		if (o.status == ffra_pkg::ST_OK && m == ffra_pkg::MODE_ALLOC) begin
			held.push_back('{int'(o.granted_start), len});
		end else if (o.status == ffra_pkg::ST_OK && held_idx >= 0) begin
			h = held[held_idx];
			held.delete(held_idx);
			if (off > 0)
				held.push_back('{h.s, off});
			if (off + len < h.l)
				held.push_back('{h.s + off + len, h.l - off - len});
		end
		pending_reqs.push_back(r);
	endtask

	task automatic gen_random(input int n);
		int p, i, off, sl, heap;
		heap = gen_tab.heap;
		repeat (n) begin
			p = $urandom_range(99);
			if (p < 8) begin
				push_req(1'($urandom_range(1)), $urandom_range(3) == 0 ? $urandom_range(65535)
					: $urandom_range(8), $urandom_range(65535), -1, 0);
			end else if (held.size() == 0 || p < 55) begin
				p = $urandom_range(99);
				if (p < 70)
					sl = $urandom_range(8, 1);
				else if (p < 90)
					sl = $urandom_range(heap / 4 + 1, 1);
				else
					sl = $urandom_range(65535);
				push_req(ffra_pkg::MODE_ALLOC, sl, $urandom_range(65535), -1, 0);
			end else begin
				i = $urandom_range(held.size() - 1);
				if ($urandom_range(3) == 0 && held[i].l > 1) begin
					off = $urandom_range(held[i].l - 1);
					sl = $urandom_range(held[i].l - off, 1);
				end else begin
					off = 0;
					sl = held[i].l;
				end
				push_req(ffra_pkg::MODE_FREE, sl, held[i].s + off, i, off);
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_heap(input int h);
		int seen;
		wait_idle();
		seen = n_cfg;
		cfg_data <= h[15:0];
		cfg_valid <= 1'b1;
		@(negedge clk);
		while (n_cfg == seen)
			@(negedge clk);
		cfg_valid <= 1'b0;
		init_table(gen_tab, h);
		held.delete();
	endtask

	// driver
	always @(negedge clk) begin
		tx_idle_pct = idle_mode == 0 ? 23 : idle_mode == 1 ? 87 : 0;
		rx_idle_pct = idle_mode == 0 ? 87 : idle_mode == 1 ? 23 : 0;
		if (arst_n) begin
			rsp_ready <= $urandom_range(99) >= rx_idle_pct;
			if (!req_valid || n_req_acc != n_req_seen) begin
				n_req_seen = n_req_acc;
				if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end else begin
			req_valid <= 1'b0;
			req <= '0;
			rsp_ready <= 1'b0;
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		ffra_pkg::rsp_t want;
		if (arst_n) begin
			stall_cycles++;
			if (cfg_valid && cfg_ready) begin
				init_table(chk_tab, cfg_data);
				n_cfg++;
				stall_cycles = 0;
			end
			if (req_valid && req_ready) begin
				expected_rsps.push_back(ffra_apply(chk_tab, req));
				n_req_acc++;
				stall_cycles = 0;
			end
			if (rsp_valid && rsp_ready) begin
				stall_cycles = 0;
				if (expected_rsps.size() == 0) begin
					report("unexpected response", rsp.status, -1);
				end else begin
					want = expected_rsps.pop_front();
					n_status[want.status]++;
					if (rsp.granted_start !== want.granted_start)
						report("granted_start", rsp.granted_start, want.granted_start);
					if (rsp.status !== want.status)
						report("status", rsp.status, want.status);
				end
			end
			if (stall_cycles > 50000) begin
				$display("timeout: no handshake for %0d cycles", stall_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		init_table(chk_tab, ffra_pkg::HeapSlotsReset);
		init_table(gen_tab, ffra_pkg::HeapSlotsReset);
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: reset heap of 1024, slots 1..1023 free
		idle_mode = 0;
		push_req(ffra_pkg::MODE_ALLOC, 0, 0, -1, 0);
		push_req(ffra_pkg::MODE_ALLOC, 65535, 16'hffff, -1, 0);
		push_req(ffra_pkg::MODE_ALLOC, 1023, 0, -1, 0);       // exact fit empties the table
		push_req(ffra_pkg::MODE_ALLOC, 1, 0, -1, 0);
		push_req(ffra_pkg::MODE_FREE, 1023, 1, -1, 0);
		push_req(ffra_pkg::MODE_FREE, 1, 0, -1, 0);           // slot 0 is reserved
		push_req(ffra_pkg::MODE_FREE, 0, 1, -1, 0);
		push_req(ffra_pkg::MODE_FREE, 65535, 65535, -1, 0);
		push_req(ffra_pkg::MODE_FREE, 5, 1020, -1, 0);        // runs past the heap
		push_req(ffra_pkg::MODE_FREE, 3, 5, -1, 0);           // overlaps free space
		push_req(ffra_pkg::MODE_ALLOC, 5, 0, -1, 0);
		push_req(ffra_pkg::MODE_ALLOC, 5, 0, -1, 0);
		push_req(ffra_pkg::MODE_ALLOC, 5, 0, -1, 0);
		push_req(ffra_pkg::MODE_ALLOC, 5, 0, -1, 0);
		push_req(ffra_pkg::MODE_FREE, 5, 6, -1, 0);           // isolated
		push_req(ffra_pkg::MODE_FREE, 5, 16, -1, 0);          // joins above
		push_req(ffra_pkg::MODE_FREE, 5, 11, -1, 0);          // joins both
		push_req(ffra_pkg::MODE_FREE, 5, 1, -1, 0);
		push_req(ffra_pkg::MODE_ALLOC, 10, 0, -1, 0);
		push_req(ffra_pkg::MODE_ALLOC, 10, 0, -1, 0);
		push_req(ffra_pkg::MODE_FREE, 5, 1, -1, 0);
		push_req(ffra_pkg::MODE_FREE, 3, 6, -1, 0);           // joins below only
		push_req(ffra_pkg::MODE_FREE, 1, 9, -1, 0);
		gen_random(150);

		write_heap(2);
		gen_random(20);
		write_heap(0);
		gen_random(8);

		idle_mode = 1;
		write_heap(65535);
		gen_random(150);
		write_heap(1);
		gen_random(8);
		write_heap(150);                            // small heap: fragments, fills table
		gen_random(200);

		idle_mode = 2;
		write_heap(1024);
		gen_random(100);
		write_heap(300);
		gen_random(120);

		wait_idle();
		repeat (200) @(negedge clk);
		$display("covered %0d heap writes; ok %0d, no space %0d, table full %0d, bad free %0d",
			n_cfg, n_status[ffra_pkg::ST_OK], n_status[ffra_pkg::ST_NO_SPACE],
			n_status[ffra_pkg::ST_TABLE_FULL], n_status[ffra_pkg::ST_BAD_FREE]);
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d responses outstanding", errors, expected_rsps.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
